// ===== rtl/core/sis_pkg.sv =====
// ----------------------------------------------------------------------------
// sis_pkg: shared definitions for the searchable item stack
// request and status codes, field widths, and the command and status bundles
// passed between the controller and the datapath
// ----------------------------------------------------------------------------
`default_nettype none

package sis_pkg;

    localparam int DEFAULT_STACK_DEPTH = 16;

    localparam int CODE_W = 16;
    localparam int AGE_W  = 8;
    localparam int CNT_W  = 5;

    // request codes
    localparam logic [1:0] REQ_PUSH   = 2'd0;
    localparam logic [1:0] REQ_POP    = 2'd1;
    localparam logic [1:0] REQ_SEARCH = 2'd2;
    localparam logic [1:0] REQ_CLEAR  = 2'd3;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic       load;
        logic       push;
        logic       pop;
        logic       clear;
        logic       rd_top;
        logic       rd_next;
        logic       finish;
        logic       take_found;
        logic [1:0] status;
    } sis_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [1:0] req;
        logic       empty;
        logic       full;
        logic       match;
        logic       ptr_zero;
    } sis_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/searchable_item_stack.sv =====
// ----------------------------------------------------------------------------
// searchable_item_stack: bounded lifo of code/age items with top-down search
// push, pop, search by code and clear; every item returns one result with
// occupancy and running even/odd age counts
// ----------------------------------------------------------------------------
//
//  channel   handshake                 payload
//  -------   -----------------------   ---------------------------------------
//  request   start & !busy             req_type, item_code, item_age
//  result    done (one-cycle strobe)   status, found_code, found_age,
//                                      occupancy, is_empty,
//                                      even_age_count, odd_age_count
//
//  push and clear: done is registered from the decode state
//  pop: adds the S_POP_WAIT state for the registered ram read of the top entry
//  search: the top entry is read in decode, then entries are examined top down
//  in S_SCAN; the single ram read port visits one entry a cycle
//  busy drops in the cycle that done is high, so a new item can follow at once
//  reset clears counters and sequencer state; the ram needs no clearing pass
//  done marks results for one cycle; they cannot be held off by the receiver
// ----------------------------------------------------------------------------
`default_nettype none

module searchable_item_stack #(
    parameter int STACK_DEPTH = sis_pkg::DEFAULT_STACK_DEPTH
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    // request
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic [1:0]                 req_type,
    input  wire logic [sis_pkg::CODE_W-1:0] item_code,
    input  wire logic [sis_pkg::AGE_W-1:0]  item_age,
    // result
    output logic                            done,
    output logic      [1:0]                 status,
    output logic      [sis_pkg::CODE_W-1:0] found_code,
    output logic      [sis_pkg::AGE_W-1:0]  found_age,
    output logic      [sis_pkg::CNT_W-1:0]  occupancy,
    output logic                            is_empty,
    output logic      [sis_pkg::CNT_W-1:0]  even_age_count,
    output logic      [sis_pkg::CNT_W-1:0]  odd_age_count
);

    // command and status between sequencer and datapath
    sis_pkg::sis_cmd_t  cmd;
    sis_pkg::sis_stat_t stat;

    // sequencer: decode, ram read wait, top-down scan
    sis_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    // datapath: item ram, counters, scan pointer and result registers
    sis_dp #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .req_type       (req_type),
        .item_code      (item_code),
        .item_age       (item_age),
        .status         (status),
        .found_code     (found_code),
        .found_age      (found_age),
        .occupancy      (occupancy),
        .is_empty       (is_empty),
        .even_age_count (even_age_count),
        .odd_age_count  (odd_age_count)
    );

`ifndef ASSERT_OFF
    // a result only closes an item that was in flight
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
    else $error("result strobe without an item in flight");

    // an accepted item keeps the block busy in the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
    else $error("accepted item did not make the block busy");

    // every stored item is counted once by parity
    a_parity_sum: assert property (@(posedge clk) disable iff (!rst_n)
        sis_pkg::CNT_W'(even_age_count + odd_age_count) == occupancy)
    else $error("even and odd age counts disagree with occupancy");

    // a full report only comes with a full stack
    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == sis_pkg::ST_FULL)
            |-> occupancy == sis_pkg::CNT_W'(STACK_DEPTH))
    else $error("full status with room left in the stack");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/sis_ram.sv =====
// ----------------------------------------------------------------------------
// sis_ram: generic simple dual-port ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module sis_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/sis_ctrl.sv =====
// ----------------------------------------------------------------------------
// sis_ctrl: request sequencer for the searchable item stack
// decodes each item, steps pop and search through the ram, and raises done
// ----------------------------------------------------------------------------
`default_nettype none

module sis_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire sis_pkg::sis_stat_t stat,
    output sis_pkg::sis_cmd_t      cmd,
    output logic                   busy,
    output logic                   done
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECODE,
        S_POP_WAIT,
        S_SCAN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   done_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_IDLE;
                case (stat.req)
                    sis_pkg::REQ_PUSH:
                    begin
                        cmd.finish = 1'b1;
                        if (stat.full)
                        begin
                            cmd.status = sis_pkg::ST_FULL;
                        end
                        else
                        begin
                            cmd.push   = 1'b1;
                            cmd.status = sis_pkg::ST_OK;
                        end
                    end
                    sis_pkg::REQ_POP:
                    begin
                        if (stat.empty)
                        begin
                            cmd.finish = 1'b1;
                            cmd.status = sis_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            cmd.rd_top = 1'b1;
                            state_next = S_POP_WAIT;
                        end
                    end
                    sis_pkg::REQ_SEARCH:
                    begin
                        if (stat.empty)
                        begin
                            cmd.finish = 1'b1;
                            cmd.status = sis_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            cmd.rd_top = 1'b1;
                            state_next = S_SCAN;
                        end
                    end
                    sis_pkg::REQ_CLEAR:
                    begin
                        cmd.clear  = 1'b1;
                        cmd.finish = 1'b1;
                        cmd.status = sis_pkg::ST_OK;
                    end
                    default:
                    begin
                        cmd.finish = 1'b1;
                    end
                endcase
            end
            S_POP_WAIT:
            begin
                cmd.pop        = 1'b1;
                cmd.finish     = 1'b1;
                cmd.take_found = 1'b1;
                cmd.status     = sis_pkg::ST_OK;
                state_next     = S_IDLE;
            end
            S_SCAN:
            begin
                if (stat.match)
                begin
                    cmd.finish     = 1'b1;
                    cmd.take_found = 1'b1;
                    cmd.status     = sis_pkg::ST_OK;
                    state_next     = S_IDLE;
                end
                else if (stat.ptr_zero)
                begin
                    cmd.finish = 1'b1;
                    cmd.status = sis_pkg::ST_NOT_FOUND;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.rd_next = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= cmd.finish;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

endmodule

`default_nettype wire

// ===== rtl/core/sis_dp.sv =====
// ----------------------------------------------------------------------------
// sis_dp: datapath of the searchable item stack
// item store, occupancy and parity counters, scan pointer, result registers
// ----------------------------------------------------------------------------
`default_nettype none

module sis_dp #(
    parameter int STACK_DEPTH = sis_pkg::DEFAULT_STACK_DEPTH
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire sis_pkg::sis_cmd_t          cmd,
    output sis_pkg::sis_stat_t              stat,
    input  wire logic [1:0]                 req_type,
    input  wire logic [sis_pkg::CODE_W-1:0] item_code,
    input  wire logic [sis_pkg::AGE_W-1:0]  item_age,
    output logic      [1:0]                 status,
    output logic      [sis_pkg::CODE_W-1:0] found_code,
    output logic      [sis_pkg::AGE_W-1:0]  found_age,
    output logic      [sis_pkg::CNT_W-1:0]  occupancy,
    output logic                            is_empty,
    output logic      [sis_pkg::CNT_W-1:0]  even_age_count,
    output logic      [sis_pkg::CNT_W-1:0]  odd_age_count
);

    localparam int AW     = $clog2(STACK_DEPTH);
    localparam int CW     = $clog2(STACK_DEPTH + 1);
    localparam int ITEM_W = sis_pkg::CODE_W + sis_pkg::AGE_W;

    // latched request
    logic [1:0]                 req_reg;
    logic [sis_pkg::CODE_W-1:0] code_reg;
    logic [sis_pkg::AGE_W-1:0]  age_reg;

    // stack bookkeeping
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [CW-1:0] even_reg;
    logic [CW-1:0] even_next;
    logic [CW-1:0] odd_reg;
    logic [CW-1:0] odd_next;
    logic [AW-1:0] ptr_reg;
    logic [AW-1:0] ptr_next;

    // result
    logic [1:0]                 status_reg;
    logic [sis_pkg::CODE_W-1:0] fcode_reg;
    logic [sis_pkg::AGE_W-1:0]  fage_reg;

    logic [CW-1:0]              count_m1;
    logic [AW-1:0]              ptr_m1;
    logic [AW-1:0]              raddr;
    logic [ITEM_W-1:0]          rdata;
    logic [sis_pkg::CODE_W-1:0] rd_code;
    logic [sis_pkg::AGE_W-1:0]  rd_age;
    logic [CW+sis_pkg::CNT_W-1:0] count_ext;
    logic [CW+sis_pkg::CNT_W-1:0] even_ext;
    logic [CW+sis_pkg::CNT_W-1:0] odd_ext;

    assign count_m1 = count_reg - CW'(1);
    assign ptr_m1   = ptr_reg - AW'(1);
    assign raddr    = cmd.rd_top ? count_m1[AW-1:0] : ptr_m1;

    sis_ram #(
        .WIDTH (ITEM_W),
        .DEPTH (STACK_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (cmd.push),
        .waddr (count_reg[AW-1:0]),
        .wdata ({code_reg, age_reg}),
        .re    (cmd.rd_top | cmd.rd_next),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign rd_code = rdata[ITEM_W-1:sis_pkg::AGE_W];
    assign rd_age  = rdata[sis_pkg::AGE_W-1:0];

    assign stat.req      = req_reg;
    assign stat.empty    = (count_reg == '0);
    assign stat.full     = (count_reg == CW'(STACK_DEPTH));
    assign stat.match    = (rd_code == code_reg);
    assign stat.ptr_zero = (ptr_reg == '0);

    always_comb
    begin
        count_next = count_reg;
        even_next  = even_reg;
        odd_next   = odd_reg;
        ptr_next   = ptr_reg;
        if (cmd.clear)
        begin
            count_next = '0;
            even_next  = '0;
            odd_next   = '0;
        end
        else if (cmd.push)
        begin
            count_next = count_reg + CW'(1);
            if (age_reg[0])
            begin
                odd_next = odd_reg + CW'(1);
            end
            else
            begin
                even_next = even_reg + CW'(1);
            end
        end
        else if (cmd.pop)
        begin
            count_next = count_m1;
            if (rd_age[0])
            begin
                if (odd_reg != '0)
                begin
                    odd_next = odd_reg - CW'(1);
                end
            end
            else if (even_reg != '0)
            begin
                even_next = even_reg - CW'(1);
            end
        end
        if (cmd.rd_top)
        begin
            ptr_next = count_m1[AW-1:0];
        end
        else if (cmd.rd_next)
        begin
            ptr_next = ptr_m1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            even_reg  <= '0;
            odd_reg   <= '0;
        end
        else
        begin
            count_reg <= count_next;
            even_reg  <= even_next;
            odd_reg   <= odd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg <= ptr_next;
        if (cmd.load)
        begin
            req_reg  <= req_type;
            code_reg <= item_code;
            age_reg  <= item_age;
        end
        if (cmd.finish)
        begin
            status_reg <= cmd.status;
            fcode_reg  <= cmd.take_found ? rd_code : '0;
            fage_reg   <= cmd.take_found ? rd_age : '0;
        end
    end

    // counts wrap to the width of the result fields
    assign count_ext = {{sis_pkg::CNT_W{1'b0}}, count_reg};
    assign even_ext  = {{sis_pkg::CNT_W{1'b0}}, even_reg};
    assign odd_ext   = {{sis_pkg::CNT_W{1'b0}}, odd_reg};

    assign status         = status_reg;
    assign found_code     = fcode_reg;
    assign found_age      = fage_reg;
    assign occupancy      = count_ext[sis_pkg::CNT_W-1:0];
    assign is_empty       = (count_reg == '0);
    assign even_age_count = even_ext[sis_pkg::CNT_W-1:0];
    assign odd_age_count  = odd_ext[sis_pkg::CNT_W-1:0];

endmodule

`default_nettype wire
